### src/gld_pkg.sv
// ----------------------------------------------------------------------------
// gld_pkg: shared definitions for the grid local peak detector
// Defaults for the size parameters, the configuration register indexes,
// output field widths and the control flags that travel with each word.
// ----------------------------------------------------------------------------
package gld_pkg;

    // Default sizes of the top level.
    localparam int DEF_MAX_COLS    = 128;
    localparam int DEF_MAX_ROWS    = 128;
    localparam int DEF_SAMPLE_BITS = 16;

    // Size register value after reset (further limited by the maximums).
    localparam int SIZE_RESET = 128;

    // Configuration port.
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 8;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COLS = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROWS = 2'd1;

    // Result field widths.
    localparam int ROW_IDX_BITS = 7;
    localparam int COL_IDX_BITS = 7;
    localparam int TOTAL_BITS   = 15;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = 15'h7fff;

    // Flags that follow a word down the pipeline.
    typedef struct packed {
        logic emit;       // a verdict is due for this word
        logic top_edge;   // decided cell lies in grid row 0
        logic left_edge;  // decided cell lies in grid column 0
        logic real_row;   // word belongs to a grid row, not the padding row
        logic real_col;   // word belongs to a grid column, not the padding column
        logic last;       // verdict for the final cell of the frame
    } t_ctl;

    // A size register value of 0 acts as 1, a value above the maximum as the maximum.
    function automatic int unsigned clamp_size(logic [CFG_DATA_BITS-1:0] v,
                                               int unsigned maxv);
        int unsigned res;
        if (v == '0) begin
            res = 1;
        end else if (32'(v) > maxv) begin
            res = maxv;
        end else begin
            res = 32'(v);
        end
        return res;
    endfunction

endpackage

### src/gld_ram.sv
// ----------------------------------------------------------------------------
// gld_ram: generic single-clock RAM
// One write port and one read port with a registered read; the read data
// holds while no read is requested.
// ----------------------------------------------------------------------------
module gld_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/gld_window.sv
// ----------------------------------------------------------------------------
// gld_window: 3x3 window and neighbor compare
// Shifts one column of three samples into the window per word and decides
// whether the center cell is strictly above all of its in-grid neighbors.
// ----------------------------------------------------------------------------
module gld_window #(
    parameter int SAMPLE_BITS = 16,
    parameter int ROW_BITS    = 8,
    parameter int COL_BITS    = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  gld_pkg::t_ctl                 i_ctl,
    input  logic [ROW_BITS-1:0]           i_row,
    input  logic [COL_BITS-1:0]           i_col,
    input  logic signed [SAMPLE_BITS-1:0] i_top,
    input  logic signed [SAMPLE_BITS-1:0] i_mid,
    input  logic signed [SAMPLE_BITS-1:0] i_bot,
    output logic                          o_valid,
    output gld_pkg::t_ctl                 o_ctl,
    output logic [ROW_BITS-1:0]           o_row,
    output logic [COL_BITS-1:0]           o_col,
    output logic                          o_peak
);

    import gld_pkg::*;

    // Window rows: 0 older line, 1 newer line, 2 incoming; column 2 is newest.
    logic signed [SAMPLE_BITS-1:0] r_win [3][3];
    logic                          r_valid;
    t_ctl                          r_ctl;
    logic [ROW_BITS-1:0]           r_row;
    logic [COL_BITS-1:0]           r_col;
    logic                          peak;

    // Pipeline valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    // Window shift and the word's position data.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ctl <= i_ctl;
            r_row <= i_row;
            r_col <= i_col;
            if (i_valid) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[k][0] <= r_win[k][1];
                    r_win[k][1] <= r_win[k][2];
                end
                r_win[0][2] <= i_top;
                r_win[1][2] <= i_mid;
                r_win[2][2] <= i_bot;
            end
        end
    end

    // Eight compares against the center; neighbors outside the grid are masked.
    always_comb begin
        logic ok;
        peak = 1'b1;
        for (int dr = 0; dr < 3; dr++) begin
            for (int dc = 0; dc < 3; dc++) begin
                ok = !(dr == 1 && dc == 1);
                if (dr == 0 && r_ctl.top_edge) ok = 1'b0;
                if (dr == 2 && !r_ctl.real_row) ok = 1'b0;
                if (dc == 0 && r_ctl.left_edge) ok = 1'b0;
                if (dc == 2 && !r_ctl.real_col) ok = 1'b0;
                if (ok && (r_win[dr][dc] >= r_win[1][1])) begin
                    peak = 1'b0;
                end
            end
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_row   = r_row;
    assign o_col   = r_col;
    assign o_peak  = peak;

endmodule

### src/grid_local_peak_detect_core.sv
// ----------------------------------------------------------------------------
// grid_local_peak_detect_core: 3x3 strict local maximum over a streamed grid
// Elevation words arrive in raster order with one padding word after each
// row and one padding row after the last row. Two line-store RAMs hold the
// two rows above; each verdict carries the cell position, a running peak
// count and a last-cell mark.
//
//   channel   direction  handshake                     payload
//   elev      in         i_elev_valid / o_elev_stall   i_elevation
//   result    out        o_res_valid / i_res_stall     o_peak_flag, o_cell_row,
//                                                      o_cell_col, o_peaks_so_far,
//                                                      o_last_cell
//   cfg       in         i_cfg_we                      i_cfg_idx, i_cfg_data
//
// One word is taken per cycle while the pipeline is not halted; a verdict
// passes the RAM read stage and then the window stage before it is loaded
// into the output register. Reset clears control state only; the line
// stores start unknown, need no clearing pass, and are only read for masked
// neighbors until written. A held result with i_res_stall high halts the
// whole pipeline and raises o_elev_stall in the same cycle.
// ----------------------------------------------------------------------------
module grid_local_peak_detect_core #(
    parameter int MAX_COLS    = gld_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS    = gld_pkg::DEF_MAX_ROWS,
    parameter int SAMPLE_BITS = gld_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration port.
    input  logic                                i_cfg_we,
    input  logic [gld_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [gld_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    // Elevation words.
    input  logic                                i_elev_valid,
    output logic                                o_elev_stall,
    input  logic signed [SAMPLE_BITS-1:0]       i_elevation,
    // Verdict words.
    output logic                                o_res_valid,
    input  logic                                i_res_stall,
    output logic                                o_peak_flag,
    output logic [gld_pkg::ROW_IDX_BITS-1:0]    o_cell_row,
    output logic [gld_pkg::COL_IDX_BITS-1:0]    o_cell_col,
    output logic [gld_pkg::TOTAL_BITS-1:0]      o_peaks_so_far,
    output logic                                o_last_cell
);

    import gld_pkg::*;

    localparam int CW = $clog2(MAX_COLS + 1);
    localparam int RW = $clog2(MAX_ROWS + 1);
    localparam int AW = $clog2(MAX_COLS);
    localparam int COLS_RESET = (MAX_COLS < SIZE_RESET) ? MAX_COLS : SIZE_RESET;
    localparam int ROWS_RESET = (MAX_ROWS < SIZE_RESET) ? MAX_ROWS : SIZE_RESET;

    // Size registers and raster position.
    logic [CW-1:0] r_cols;
    logic [RW-1:0] r_rows;
    logic [CW-1:0] r_col_pos;
    logic [RW-1:0] r_row_pos;
    logic [CW-1:0] n_col_pos;
    logic [RW-1:0] n_row_pos;
    logic          cfg_hit;

    // Pipeline control.
    logic adv;
    logic accept;
    t_ctl cur_ctl;

    // RAM read stage.
    logic                          r_s1_valid;
    t_ctl                          r_s1_ctl;
    logic [RW-1:0]                 r_s1_row;
    logic [CW-1:0]                 r_s1_col;
    logic [AW-1:0]                 r_s1_addr;
    logic signed [SAMPLE_BITS-1:0] r_s1_sample;
    logic [SAMPLE_BITS-1:0]        older_rdata;
    logic [SAMPLE_BITS-1:0]        newer_rdata;
    logic signed [SAMPLE_BITS-1:0] top;
    logic signed [SAMPLE_BITS-1:0] mid;
    logic signed [SAMPLE_BITS-1:0] bot;
    logic                          store_we;

    // Window stage outputs.
    logic          s2_valid;
    t_ctl          s2_ctl;
    logic [RW-1:0] s2_row;
    logic [CW-1:0] s2_col;
    logic          s2_peak;

    // Output stage.
    logic                    r_o_valid;
    logic                    r_o_peak;
    logic [ROW_IDX_BITS-1:0] r_o_row;
    logic [COL_IDX_BITS-1:0] r_o_col;
    logic [TOTAL_BITS-1:0]   r_o_total;
    logic                    r_o_last;
    logic [TOTAL_BITS-1:0]   r_total;
    logic [TOTAL_BITS-1:0]   n_total;

    // The pipeline moves when the output register is empty or being taken.
    assign adv          = !r_o_valid || !i_res_stall;
    assign accept       = i_elev_valid && adv;
    assign o_elev_stall = !adv;

    // A write to a listed register restarts the frame.
    assign cfg_hit = i_cfg_we && ((i_cfg_idx == CFG_COLS) || (i_cfg_idx == CFG_ROWS));

    // Size registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= CW'(COLS_RESET);
            r_rows <= RW'(ROWS_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COLS: r_cols <= CW'(clamp_size(i_cfg_data, MAX_COLS));
                CFG_ROWS: r_rows <= RW'(clamp_size(i_cfg_data, MAX_ROWS));
                default:  ;
            endcase
        end
    end

    // Next raster position, wrapping after the padding column and padding row.
    always_comb begin
        n_col_pos = CW'(r_col_pos + 1'b1);
        n_row_pos = r_row_pos;
        if (r_col_pos == r_cols) begin
            n_col_pos = '0;
            n_row_pos = (r_row_pos == r_rows) ? '0 : RW'(r_row_pos + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos <= '0;
            r_row_pos <= '0;
        end else if (cfg_hit) begin
            r_col_pos <= '0;
            r_row_pos <= '0;
        end else if (accept) begin
            r_col_pos <= n_col_pos;
            r_row_pos <= n_row_pos;
        end
    end

    // Flags for the incoming word.
    always_comb begin
        cur_ctl.emit      = (r_row_pos != '0) && (r_col_pos != '0);
        cur_ctl.top_edge  = (r_row_pos == RW'(1));
        cur_ctl.left_edge = (r_col_pos == CW'(1));
        cur_ctl.real_row  = (r_row_pos < r_rows);
        cur_ctl.real_col  = (r_col_pos < r_cols);
        cur_ctl.last      = (r_row_pos == r_rows) && (r_col_pos == r_cols);
    end

    // Line stores: read at acceptance, written back one stage later.
    gld_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_COLS)
    ) u_older_ram (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_s1_addr),
        .i_wdata (newer_rdata),
        .i_re    (accept && cur_ctl.real_col),
        .i_raddr (r_col_pos[AW-1:0]),
        .o_rdata (older_rdata)
    );

    gld_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_COLS)
    ) u_newer_ram (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_s1_addr),
        .i_wdata (r_s1_sample),
        .i_re    (accept && cur_ctl.real_col),
        .i_raddr (r_col_pos[AW-1:0]),
        .o_rdata (newer_rdata)
    );

    // RAM read stage registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ctl    <= cur_ctl;
            r_s1_row    <= RW'(r_row_pos - 1'b1);
            r_s1_col    <= CW'(r_col_pos - 1'b1);
            r_s1_addr   <= r_col_pos[AW-1:0];
            r_s1_sample <= i_elevation;
        end
    end

    // New window column; padding positions enter as zero.
    assign top      = r_s1_ctl.real_col ? $signed(older_rdata) : '0;
    assign mid      = r_s1_ctl.real_col ? $signed(newer_rdata) : '0;
    assign bot      = (r_s1_ctl.real_col && r_s1_ctl.real_row) ? r_s1_sample : '0;
    assign store_we = adv && r_s1_valid && r_s1_ctl.real_col && r_s1_ctl.real_row;

    gld_window #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ROW_BITS    (RW),
        .COL_BITS    (CW)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_s1_valid),
        .i_ctl   (r_s1_ctl),
        .i_row   (r_s1_row),
        .i_col   (r_s1_col),
        .i_top   (top),
        .i_mid   (mid),
        .i_bot   (bot),
        .o_valid (s2_valid),
        .o_ctl   (s2_ctl),
        .o_row   (s2_row),
        .o_col   (s2_col),
        .o_peak  (s2_peak)
    );

    // Saturating peak count including the current cell.
    assign n_total = (s2_peak && (r_total != TOTAL_MAX)) ? TOTAL_BITS'(r_total + 1'b1)
                                                        : r_total;

    // Output register and running total; the total clears after the last cell and on a frame restart.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_total   <= '0;
        end else if (cfg_hit) begin
            r_total <= '0;
        end else if (adv) begin
            r_o_valid <= s2_valid && s2_ctl.emit;
            if (s2_valid && s2_ctl.emit) begin
                r_total <= s2_ctl.last ? '0 : n_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && s2_valid && s2_ctl.emit) begin
            r_o_peak  <= s2_peak;
            r_o_row   <= ROW_IDX_BITS'(s2_row);
            r_o_col   <= COL_IDX_BITS'(s2_col);
            r_o_total <= n_total;
            r_o_last  <= s2_ctl.last;
        end
    end

    assign o_res_valid    = r_o_valid;
    assign o_peak_flag    = r_o_peak;
    assign o_cell_row     = r_o_row;
    assign o_cell_col     = r_o_col;
    assign o_peaks_so_far = r_o_total;
    assign o_last_cell    = r_o_last;

endmodule
